### rtl/binary_image_2x2_cover_check_defines.svh
// Assertion macros for the 2x2 cover check block.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef BINARY_IMAGE_2X2_COVER_CHECK_DEFINES_SVH
`define BINARY_IMAGE_2X2_COVER_CHECK_DEFINES_SVH

`define BIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BIC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bic_pkg.sv
// Shared constants, types and helpers of the 2x2 cover check block.
// No dependencies; imported by all other files but bic_line_buf and the .svh.
package bic_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 1024;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_W     = 10;
    localparam int TOTAL_W   = 20;

    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = CFG_IDX_W'(1);

    typedef struct packed {
        logic               window_full;
        logic [WIN_W-1:0]   window_row;
        logic [WIN_W-1:0]   window_col;
        logic [TOTAL_W-1:0] window_total;
        logic               uncovered_seen;
        logic               frame_last;
    } t_result;

    // pixel of the row above at this column, window flag of the row above
    // for the window ending at this column
    typedef struct packed {
        logic pix;
        logic flag;
    } t_lb_word;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    function automatic logic [ROW_W-1:0] row_size_m1(input logic [CFG_W-1:0] v);
        logic [31:0] eff;
        eff = 32'(v);
        if (eff < 32'd2) eff = 32'd2;
        if (eff > 32'(MAX_ROWS)) eff = 32'(MAX_ROWS);
        return ROW_W'(eff - 32'd1);
    endfunction

    function automatic logic [COL_W-1:0] col_size_m1(input logic [CFG_W-1:0] v);
        logic [31:0] eff;
        eff = 32'(v);
        if (eff < 32'd2) eff = 32'd2;
        if (eff > 32'(MAX_COLS)) eff = 32'(MAX_COLS);
        return COL_W'(eff - 32'd1);
    endfunction

endpackage

### rtl/bic_if.sv
// Channel interfaces: pixel input, result output, register write.
// Depends on bic_pkg.
interface bic_pix_if;
    logic valid;
    logic ready;
    logic pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bic_res_if;
    import bic_pkg::*;
    logic               valid;
    logic               ready;
    logic               window_full;
    logic [WIN_W-1:0]   window_row;
    logic [WIN_W-1:0]   window_col;
    logic [TOTAL_W-1:0] window_total;
    logic               uncovered_seen;
    logic               frame_last;
    modport source (output valid, output window_full, output window_row, output window_col,
                    output window_total, output uncovered_seen, output frame_last,
                    input ready);
    modport sink   (input valid, input window_full, input window_row, input window_col,
                    input window_total, input uncovered_seen, input frame_last,
                    output ready);
endinterface

interface bic_cfg_if;
    import bic_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bic_line_buf.sv
// Single-port-write, registered-read line buffer.
// No dependencies.
module bic_line_buf #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bic_core.sv
// Window detect, count and cover judgment for one pixel per beat.
// Depends on bic_pkg; reads and writes the line buffer in bic_line_buf.
module bic_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_pixel,
    input  logic                            i_cfg_we,
    input  logic [bic_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bic_pkg::CFG_W-1:0]       i_cfg_data,
    input  bic_pkg::t_lb_word               i_rd_data,
    output logic                            o_rd_en,
    output logic [bic_pkg::COL_W-1:0]       o_rd_addr,
    output logic                            o_wr_en,
    output logic [bic_pkg::COL_W-1:0]       o_wr_addr,
    output bic_pkg::t_lb_word               o_wr_data,
    output bic_pkg::t_result                o_res,
    output bic_pkg::t_pos                   o_pos
);
    import bic_pkg::*;

    logic [ROW_W-1:0]   r_rows_m1, r_row, n_row;
    logic [COL_W-1:0]   r_cols_m1, r_col, n_col;
    logic [TOTAL_W-1:0] r_count, n_count;
    logic               r_unc, n_unc;
    logic               r_left, r_corner, r_prev_full, r_prev_o1;

    logic has_win, row_ge2, col_ge2;
    logic last_col, last_row, last;
    logic above, full, o1, o2, n2, unc_now;

    always_comb begin
        has_win  = (r_row != '0) && (r_col != '0);
        row_ge2  = r_row > ROW_W'(1);
        col_ge2  = r_col > COL_W'(1);
        last_col = r_col == r_cols_m1;
        last_row = r_row == r_rows_m1;
        last     = last_col && last_row;
        above    = i_rd_data.pix;

        full = has_win && r_corner && above && r_left && i_pixel;
        o1   = row_ge2 && i_rd_data.flag;
        o2   = row_ge2 && col_ge2 && r_prev_o1;
        n2   = col_ge2 && r_prev_full;

        unc_now = has_win && ((r_corner && !(o1 || o2 || full || n2))
                           || (last_col && above && !(o1 || full))
                           || (last_row && r_left && !(full || n2))
                           || (last && i_pixel && !full));

        n_count = (full && (r_count != TOTAL_MAX)) ? r_count + TOTAL_W'(1) : r_count;
        n_unc   = r_unc || unc_now;

        n_row = r_row;
        n_col = r_col + COL_W'(1);
        if (last) begin
            n_row = '0;
            n_col = '0;
        end else if (last_col) begin
            n_row = r_row + ROW_W'(1);
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1   <= row_size_m1(CFG_W'(MAX_ROWS));
            r_cols_m1   <= col_size_m1(CFG_W'(MAX_COLS));
            r_row       <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_unc       <= 1'b0;
            r_left      <= 1'b0;
            r_corner    <= 1'b0;
            r_prev_full <= 1'b0;
            r_prev_o1   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_rows_m1 <= row_size_m1(i_cfg_data);
                CFG_COLS: r_cols_m1 <= col_size_m1(i_cfg_data);
                default: ;
            endcase
            r_row       <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_unc       <= 1'b0;
            r_left      <= 1'b0;
            r_corner    <= 1'b0;
            r_prev_full <= 1'b0;
            r_prev_o1   <= 1'b0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
            if (last) begin
                r_count     <= '0;
                r_unc       <= 1'b0;
                r_left      <= 1'b0;
                r_corner    <= 1'b0;
                r_prev_full <= 1'b0;
                r_prev_o1   <= 1'b0;
            end else if (last_col) begin
                r_count     <= n_count;
                r_unc       <= n_unc;
                r_left      <= 1'b0;
                r_corner    <= 1'b0;
                r_prev_full <= 1'b0;
                r_prev_o1   <= 1'b0;
            end else begin
                r_count     <= n_count;
                r_unc       <= n_unc;
                r_left      <= i_pixel;
                r_corner    <= above;
                r_prev_full <= full;
                r_prev_o1   <= i_rd_data.flag;
            end
        end
    end

    // prefetch the next column so its word is ready when its pixel arrives
    assign o_rd_en        = i_accept;
    assign o_rd_addr      = n_col;
    assign o_wr_en        = i_accept;
    assign o_wr_addr      = r_col;
    assign o_wr_data.pix  = i_pixel;
    assign o_wr_data.flag = full;

    assign o_res.window_full    = full;
    assign o_res.window_row     = has_win ? WIN_W'(r_row) : '0;
    assign o_res.window_col     = has_win ? WIN_W'(r_col) : '0;
    assign o_res.window_total   = n_count;
    assign o_res.uncovered_seen = n_unc;
    assign o_res.frame_last     = last;

    assign o_pos.row = r_row;
    assign o_pos.col = r_col;

endmodule

### rtl/bic_out_stage.sv
// Result register with pass-through backpressure.
// Depends on bic_pkg.
module bic_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bic_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_valid,
    output bic_pkg::t_result o_res
);
    import bic_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/binary_image_2x2_cover_check.sv
// Latency: a result is valid in the cycle after its pixel beat is accepted.
// Throughput: one pixel per cycle unless stalled; the line buffer is read one
// column ahead, written at the current one, one access of each kind per beat.
// Reset clears position, count and flag and sets both sizes to 1024.
// The line buffer needs no clearing pass; the block is ready right after reset.
`include "binary_image_2x2_cover_check_defines.svh"
module binary_image_2x2_cover_check (
    input logic      i_clk,
    input logic      i_rst_n,
    bic_pix_if.sink  i_pix,
    bic_cfg_if.sink  i_cfg,
    bic_res_if.source o_res
);
    import bic_pkg::*;

    logic     s_accept, s_in_ready, s_rd_en, s_wr_en, s_out_valid;
    logic [COL_W-1:0] s_rd_addr, s_wr_addr;
    t_lb_word s_rd_data, s_wr_data;
    t_result  s_res, s_out_res;
    t_pos     s_pos;

    assign i_pix.ready = s_in_ready;
    assign i_cfg.ready = 1'b1;
    assign s_accept    = i_pix.valid && s_in_ready;

    bic_line_buf #(
        .DEPTH (MAX_COLS),
        .WIDTH ($bits(t_lb_word))
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    bic_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_pixel    (i_pix.pixel),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_rd_data  (s_rd_data),
        .o_rd_en    (s_rd_en),
        .o_rd_addr  (s_rd_addr),
        .o_wr_en    (s_wr_en),
        .o_wr_addr  (s_wr_addr),
        .o_wr_data  (s_wr_data),
        .o_res      (s_res),
        .o_pos      (s_pos)
    );

    bic_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_accept),
        .i_res       (s_res),
        .i_out_ready (o_res.ready),
        .o_in_ready  (s_in_ready),
        .o_valid     (s_out_valid),
        .o_res       (s_out_res)
    );

    assign o_res.valid          = s_out_valid;
    assign o_res.window_full    = s_out_res.window_full;
    assign o_res.window_row     = s_out_res.window_row;
    assign o_res.window_col     = s_out_res.window_col;
    assign o_res.window_total   = s_out_res.window_total;
    assign o_res.uncovered_seen = s_out_res.uncovered_seen;
    assign o_res.frame_last     = s_out_res.frame_last;

    `BIC_ASSERT_IMP(a_no_accept_on_stall, o_res.valid && !o_res.ready, !i_pix.ready, "pixel taken while result stalled")
    `BIC_ASSERT_IMP(a_full_has_position, o_res.valid && o_res.window_full, (o_res.window_row != '0) && (o_res.window_col != '0), "full window without position")
    `BIC_ASSERT_NXT(a_frame_end_restart, s_accept && s_res.frame_last, (s_pos.row == '0) && (s_pos.col == '0), "position not restarted after frame end")

endmodule

### dv/bic_cover_checker.sv
// Watches the pixel, result and register channels of the 2x2 cover check block,
// predicts each result beat and compares it field by field.
// Depends on bic_pkg and the channel interfaces in bic_if.sv.
module bic_cover_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bic_pix_if   i_pix,
    bic_res_if   i_res,
    bic_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_seen,
    output int   o_frames_done,
    output int   o_windows_seen,
    output int   o_uncovered_frames
);
    timeunit 1ns;
    timeprecision 1ps;
    import bic_pkg::*;

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             line_pix   [MAX_COLS];
    logic             older_win  [MAX_COLS];
    logic             recent_win [MAX_COLS];
    logic             left_pix;
    logic             corner_pix;
    logic             uncov_flag;
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      win_count;
    t_result          pending_results [$];
    int               fail_total;
    int               results_seen;
    int               frames_done;
    int               windows_seen;
    int               uncovered_frames;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned limit);
        if (v < 2) return 2;
        if (v > limit) return limit;
        return int'(v);
    endfunction

    function automatic void clear_frame();
        foreach (line_pix[i]) begin
            line_pix[i]   = 1'b0;
            older_win[i]  = 1'b0;
            recent_win[i] = 1'b0;
        end
        left_pix   = 1'b0;
        corner_pix = 1'b0;
        uncov_flag = 1'b0;
        row_pos    = 0;
        col_pos    = 0;
        win_count  = 0;
    endfunction

    function automatic t_result next_window_result(input logic p);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        logic        above;
        logic        full;
        logic        o1, o2, n1, n2;
        logic        end_col;
        logic        end_row;
        logic        has_win;
        t_result     res_exp;
        nrows   = clamp_size(rows_reg, MAX_ROWS);
        ncols   = clamp_size(cols_reg, MAX_COLS);
        r       = row_pos;
        c       = col_pos;
        above   = line_pix[c];
        full    = 1'b0;
        end_col = (c == ncols - 1);
        end_row = (r == nrows - 1);
        has_win = (r >= 1) && (c >= 1);
        if (has_win) begin
            full = corner_pix & above & left_pix & p;
            recent_win[c-1] = full;
            if (full && win_count < TOTAL_MAX) win_count++;
            o1 = (r >= 2) ? older_win[c-1] : 1'b0;
            o2 = (r >= 2 && c >= 2) ? older_win[c-2] : 1'b0;
            n1 = recent_win[c-1];
            n2 = (c >= 2) ? recent_win[c-2] : 1'b0;
            if (corner_pix && !(o1 | o2 | n1 | n2)) uncov_flag = 1'b1;
            if (end_col && above && !(o1 | n1)) uncov_flag = 1'b1;
            if (end_row && left_pix && !(n1 | n2)) uncov_flag = 1'b1;
            if (end_col && end_row && p && !n1) uncov_flag = 1'b1;
        end
        res_exp.window_full    = full;
        res_exp.window_row     = has_win ? WIN_W'(r) : '0;
        res_exp.window_col     = has_win ? WIN_W'(c) : '0;
        res_exp.window_total   = TOTAL_W'(win_count);
        res_exp.uncovered_seen = uncov_flag;
        res_exp.frame_last     = end_col && end_row;
        corner_pix  = above;
        line_pix[c] = p;
        left_pix    = p;
        if (end_col && end_row) begin
            clear_frame();
        end else if (end_col) begin
            older_win = recent_win;
            foreach (recent_win[i]) recent_win[i] = 1'b0;
            col_pos    = 0;
            left_pix   = 1'b0;
            corner_pix = 1'b0;
            row_pos    = r + 1;
        end else begin
            col_pos = c + 1;
        end
        return res_exp;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rows_reg = CFG_W'(MAX_ROWS);
            cols_reg = CFG_W'(MAX_COLS);
            clear_frame();
            pending_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                if (i_res.window_full) windows_seen++;
                if (i_res.frame_last) begin
                    frames_done++;
                    if (i_res.uncovered_seen) uncovered_frames++;
                end
                if (pending_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("window_full", 32'(want.window_full),
                                  32'(i_res.window_full));
                    compare_field("window_row", 32'(want.window_row),
                                  32'(i_res.window_row));
                    compare_field("window_col", 32'(want.window_col),
                                  32'(i_res.window_col));
                    compare_field("window_total", 32'(want.window_total),
                                  32'(i_res.window_total));
                    compare_field("uncovered_seen", 32'(want.uncovered_seen),
                                  32'(i_res.uncovered_seen));
                    compare_field("frame_last", 32'(want.frame_last),
                                  32'(i_res.frame_last));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ROWS: rows_reg = i_cfg.data;
                    CFG_COLS: cols_reg = i_cfg.data;
                    default: ;
                endcase
                clear_frame();
            end
            if (i_pix.valid && i_pix.ready) begin
                pending_results.push_back(next_window_result(i_pix.pixel));
            end
        end
        o_fail_count       <= fail_total;
        o_pending          <= pending_results.size();
        o_results_seen     <= results_seen;
        o_frames_done      <= frames_done;
        o_windows_seen     <= windows_seen;
        o_uncovered_frames <= uncovered_frames;
    end

endmodule

### dv/tb_binary_image_2x2_cover_check.sv
// Top of the 2x2 cover check testbench: clock, reset, pixel and register stimulus,
// result back-pressure and the final verdict.
// Depends on bic_pkg, bic_if.sv, bic_cover_checker and the block itself.
module tb_binary_image_2x2_cover_check;
    timeunit 1ns;
    timeprecision 1ps;
    import bic_pkg::*;

    localparam int RANDOM_ITEMS    = 500;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PARTIAL_ITEMS   = 150;

    typedef enum int {IMG_RANDOM, IMG_SQUARES, IMG_SQUARES_NOISE, IMG_ONES, IMG_ZEROS}
        t_img_style;
    typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} t_idle_mode;

    logic i_clk;
    logic i_rst_n;

    bic_pix_if pix_ch ();
    bic_res_if res_ch ();
    bic_cfg_if cfg_ch ();

    int         fail_count;
    int         pending;
    int         results_seen;
    int         frames_done;
    int         windows_seen;
    int         uncovered_frames;
    int         pixels_sent;
    bit         offering;
    bit         hold_off_req;
    t_idle_mode source_mode;
    logic       img_bits [];

    binary_image_2x2_cover_check dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    bic_cover_checker cover_mon (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix             (pix_ch),
        .i_res             (res_ch),
        .i_cfg             (cfg_ch),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_seen    (results_seen),
        .o_frames_done     (frames_done),
        .o_windows_seen    (windows_seen),
        .o_uncovered_frames(uncovered_frames)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int draw_gap(input t_idle_mode mode);
        case (mode)
            IDLE_HEAVY: return $urandom_range(0, 11);
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
            default:    return 0;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] size_code(input int unsigned eff);
        if (eff == 2 && $urandom_range(0, 3) == 0) return CFG_W'($urandom_range(0, 1));
        return CFG_W'(eff);
    endfunction

    function automatic void build_image(input int unsigned nrows, input int unsigned ncols,
                                        input t_img_style style);
        int unsigned density;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        img_bits = new[nrows * ncols];
        density  = $urandom_range(1, 3);
        foreach (img_bits[i]) begin
            case (style)
                IMG_RANDOM: img_bits[i] = ($urandom_range(0, 3) < density);
                IMG_ONES:   img_bits[i] = 1'b1;
                default:    img_bits[i] = 1'b0;
            endcase
        end
        if (style == IMG_SQUARES || style == IMG_SQUARES_NOISE) begin
            repeat ($urandom_range(1, (nrows * ncols) / 3 + 1)) begin
                r = $urandom_range(0, nrows - 2);
                c = $urandom_range(0, ncols - 2);
                img_bits[r * ncols + c]           = 1'b1;
                img_bits[r * ncols + c + 1]       = 1'b1;
                img_bits[(r + 1) * ncols + c]     = 1'b1;
                img_bits[(r + 1) * ncols + c + 1] = 1'b1;
            end
        end
        if (style == IMG_SQUARES_NOISE) begin
            idx = $urandom_range(0, nrows * ncols - 1);
            img_bits[idx] = ~img_bits[idx];
        end
    endfunction

    task automatic send_pixel(input logic val);
        int gap;
        gap = draw_gap(source_mode);
        if (gap > 0) begin
            if (offering) pix_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= val;
        offering = 1'b1;
        do @(posedge i_clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        if (offering) pix_ch.valid <= 1'b0;
        offering = 1'b0;
        while (results_seen != pixels_sent) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows_code,
                            input logic [CFG_W-1:0] cols_code);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ROWS;
        cfg_ch.data  <= rows_code;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_COLS;
        cfg_ch.data  <= cols_code;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_image(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(img_bits[i]);
    endtask

    task automatic send_list(input logic [15:0] bits, input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(bits[count - 1 - i]);
    endtask

    initial begin : result_drain
        int         gap;
        int         beats_left;
        t_idle_mode sink_mode;
        res_ch.ready <= 1'b0;
        sink_mode  = IDLE_NONE;
        beats_left = 40;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (beats_left == 0) begin
                sink_mode  = t_idle_mode'($urandom_range(0, 2));
                beats_left = $urandom_range(20, 80);
            end
            beats_left--;
            gap = draw_gap(sink_mode);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        int unsigned random_items;
        int unsigned phase;
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned cur_rows;
        int unsigned cur_cols;
        int unsigned count;
        int unsigned pick;
        t_img_style  style;
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ROWS;
        cfg_ch.data  <= '0;
        offering     = 1'b0;
        hold_off_req = 1'b0;
        pixels_sent  = 0;
        source_mode  = IDLE_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(CFG_W'(0), CFG_W'(1));
        send_list(16'b1111, 4);
        send_list(16'b1110, 4);
        send_list(16'b0000, 4);
        set_size(CFG_W'(3), CFG_W'(2));
        send_list(16'b111110, 6);
        set_size(CFG_W'(2), CFG_W'(3));
        send_list(16'b111110, 6);

        source_mode = IDLE_LIGHT;
        set_size(CFG_W'(2047), CFG_W'(2));
        build_image(MAX_ROWS, 2, IMG_ONES);
        send_image(PARTIAL_ITEMS);
        set_size(CFG_W'(2), CFG_W'(1025));
        build_image(2, MAX_COLS, IMG_SQUARES_NOISE);
        send_image(PARTIAL_ITEMS);
        set_size(CFG_W'(MAX_ROWS), CFG_W'(MAX_COLS));
        build_image(1, 50, IMG_RANDOM);
        send_image(50);

        random_items = 0;
        phase        = 0;
        cur_rows     = 2;
        cur_cols     = 2;
        while (random_items < RANDOM_ITEMS) begin
            phase++;
            source_mode = t_idle_mode'($urandom_range(0, 2));
            rows_eff = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 6);
            cols_eff = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 6);
            if (phase % 17 == 1) begin
                rows_eff = 8;
                cols_eff = 8;
            end
            if (phase == 1 || phase % 17 == 1 || $urandom_range(0, 4) != 0) begin
                set_size(size_code(rows_eff), size_code(cols_eff));
                cur_rows = rows_eff;
                cur_cols = cols_eff;
            end
            if (phase % 17 == 1) begin
                hold_off_req = 1'b1;
                source_mode  = IDLE_NONE;
            end
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) style = IMG_SQUARES;
                else if (pick < 6) style = IMG_SQUARES_NOISE;
                else if (pick == 6) style = IMG_ONES;
                else if (pick == 7) style = IMG_ZEROS;
                else style = IMG_RANDOM;
                build_image(cur_rows, cur_cols, style);
                count = cur_rows * cur_cols;
                if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count - 1);
                send_image(count);
                random_items += count;
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0) $error("%0d predicted results never arrived", pending);
        $display("Sent %0d pixels: %0d frames completed, %0d full windows reported,",
                 pixels_sent, frames_done, windows_seen);
        $display("%0d frames ended with an uncovered one-pixel.", uncovered_frames);
        if (fail_count == 0 && pending == 0) begin
            $display("binary_image_2x2_cover_check test passed");
        end else begin
            $display("binary_image_2x2_cover_check test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("binary_image_2x2_cover_check test failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/bic_pkg.sv
rtl/bic_if.sv
rtl/bic_line_buf.sv
rtl/bic_core.sv
rtl/bic_out_stage.sv
rtl/binary_image_2x2_cover_check.sv
dv/bic_cover_checker.sv
dv/tb_binary_image_2x2_cover_check.sv
